// ----- src/dkm_pkg.sv -----
`default_nettype none
package dkm_pkg;

  // pipeline control shared by the top level and its dividers
  typedef struct packed {
    logic en;
    logic valid;
  } dkm_ctl_t;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_X      = 3'd0;
  localparam logic [2:0] REG_KEY_Y      = 3'd1;
  localparam logic [2:0] REG_KEY_Z      = 3'd2;
  localparam logic [2:0] REG_DUAL_KEY_X = 3'd3;
  localparam logic [2:0] REG_DUAL_KEY_Y = 3'd4;
  localparam logic [2:0] REG_DUAL_KEY_Z = 3'd5;

endpackage
`default_nettype wire

// ----- src/dkm_div.sv -----
`default_nettype none
module dkm_div #(
  parameter int NW = 38,
  parameter int DW = 21,
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dkm_pkg::dkm_ctl_t ctl,
  input  wire logic [NW-1:0]     num,
  input  wire logic [DW-1:0]     den,
  input  wire logic [SW-1:0]     side_in,
  output logic                   out_valid,
  output logic [NW-1:0]          quo,
  output logic [SW-1:0]          side_out
);
  import dkm_pkg::*;

  // one quotient bit per stage, restoring, unsigned
  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic          p_vld  [NW];
  logic [DW-1:0] p_rem  [NW];
  logic [NW-1:0] p_num  [NW];
  logic [NW-1:0] p_quo  [NW];
  logic [DW-1:0] p_den  [NW];
  logic [SW-1:0] p_side [NW];

  assign p_vld[0]  = ctl.valid;
  assign p_rem[0]  = '0;
  assign p_num[0]  = num;
  assign p_quo[0]  = '0;
  assign p_den[0]  = den;
  assign p_side[0] = side_in;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (s > 0) begin : g_link
      assign p_vld[s]  = vld_q[s-1];
      assign p_rem[s]  = rem_q[s-1];
      assign p_num[s]  = num_q[s-1];
      assign p_quo[s]  = quo_q[s-1];
      assign p_den[s]  = den_q[s-1];
      assign p_side[s] = side_q[s-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {p_rem[s], p_num[s][NW-1]};
    assign diff  = trial - {1'b0, p_den[s]};
    assign ge    = (trial >= {1'b0, p_den[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[s] <= p_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[s]  <= p_num[s] << 1;
        quo_q[s]  <= {p_quo[s][NW-2:0], ge};
        den_q[s]  <= p_den[s];
        side_q[s] <= p_side[s];
      end
    end
  end

  assign out_valid = vld_q[NW-1];
  assign quo       = quo_q[NW-1];
  assign side_out  = side_q[NW-1];

endmodule
`default_nettype wire

// ----- src/dual_key_matte_pixel_top.sv -----
`default_nettype none
// Dual-key difference matte, one pixel per clock unless the receiver stalls.
// Input channel (in_valid/in_ready) carries a pixel shot over key one (main_*)
// and the same pixel shot over key two (dual_*), plus last_in. The output
// channel (out_valid/out_ready) returns the recovered pixel and last_out.
// Keys are set through cfg_we/cfg_index/cfg_data; the user must set them only
// while the block is idle, and the block itself does not enforce this.
// Throughput: one transfer per clock on each side unless the receiver stalls.
// The datapath holds two radix-2 divider pipelines of one quotient bit per
// stage: one for the per-channel alphas and one for the colour un-mixing.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and in_ready drops in the same cycle,
// so nothing is lost or repeated.
// Reset clears all valid bits and sets the keys to zero; no pass over
// storage is needed after reset.
module dual_key_matte_pixel_top #(
  parameter int VALUE_BITS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic signed [VALUE_BITS-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] main_x,
  input  wire logic signed [VALUE_BITS-1:0] main_y,
  input  wire logic signed [VALUE_BITS-1:0] main_z,
  input  wire logic signed [VALUE_BITS-1:0] main_alpha,
  input  wire logic signed [VALUE_BITS-1:0] dual_x,
  input  wire logic signed [VALUE_BITS-1:0] dual_y,
  input  wire logic signed [VALUE_BITS-1:0] dual_z,
  input  wire logic signed [VALUE_BITS-1:0] dual_alpha,
  input  wire logic                         last_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [VALUE_BITS-1:0]      out_x,
  output logic signed [VALUE_BITS-1:0]      out_y,
  output logic signed [VALUE_BITS-1:0]      out_z,
  output logic signed [VALUE_BITS-1:0]      out_alpha,
  output logic                              last_out
);
  import dkm_pkg::*;

  localparam int V    = VALUE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NA   = V + 2;
  localparam int KW   = V + 1;
  localparam int NW   = V + 2 + F;
  localparam int PW   = 2 * V;
  localparam int SATW = (PW > NW + 2) ? PW : NW + 2;
  localparam int SW1  = 2 + NA + KW;
  localparam int SW2  = 1 + KW;
  localparam int CW1  = 1 + V + 3 * V + 1;
  localparam int CW2  = 2 + V + 3 * V + 1 + PW;
  localparam logic signed [SATW-1:0] SMAX = SATW'((64'sd1 <<< (V - 1)) - 64'sd1);
  localparam logic signed [SATW-1:0] SMIN = -SMAX - SATW'(1);

  function automatic logic signed [V-1:0] sat_v(input logic signed [SATW-1:0] s);
    logic signed [V-1:0] r;
    if (s > SMAX) begin
      r = SMAX[V-1:0];
    end else if (s < SMIN) begin
      r = SMIN[V-1:0];
    end else begin
      r = s[V-1:0];
    end
    return r;
  endfunction

  // pipeline advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // key registers
  logic signed [V-1:0] key1 [3];
  logic signed [V-1:0] key2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        key1[i] <= '0;
        key2[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_X:      key1[0] <= cfg_data;
        REG_KEY_Y:      key1[1] <= cfg_data;
        REG_KEY_Z:      key1[2] <= cfg_data;
        REG_DUAL_KEY_X: key2[0] <= cfg_data;
        REG_DUAL_KEY_Y: key2[1] <= cfg_data;
        REG_DUAL_KEY_Z: key2[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [V-1:0] c1 [3];
  logic signed [V-1:0] c2 [3];
  assign c1[0] = main_x;
  assign c1[1] = main_y;
  assign c1[2] = main_z;
  assign c2[0] = dual_x;
  assign c2[1] = dual_y;
  assign c2[2] = dual_z;

  // stage a: differences, sums and flags
  logic                 a_valid;
  logic signed [NA-1:0] a_num  [3];
  logic signed [KW-1:0] a_den  [3];
  logic signed [NA-1:0] a_n2   [3];
  logic signed [KW-1:0] a_ksum [3];
  logic                 a_zero [3];
  logic                 a_eq;
  logic signed [V-1:0]  a_avg;
  logic signed [V-1:0]  a_main [3];
  logic                 a_last;
  logic signed [V:0]    asum;

  assign asum = KW'(main_alpha) + KW'(dual_alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_num[i]  <= (NA'(c2[i]) - NA'(c1[i])) + (NA'(key1[i]) - NA'(key2[i]));
        a_den[i]  <= KW'(key1[i]) - KW'(key2[i]);
        a_n2[i]   <= (NA'(c1[i]) - NA'(key1[i])) + (NA'(c2[i]) - NA'(key2[i]));
        a_ksum[i] <= KW'(key1[i]) + KW'(key2[i]);
        a_zero[i] <= (c1[i] == c2[i]) || (key1[i] == key2[i]);
        a_main[i] <= c1[i];
      end
      a_eq   <= (c1[0] == c2[0]) && (c1[1] == c2[1]) && (c1[2] == c2[2]);
      a_avg  <= asum[V:1];
      a_last <= last_in;
    end
  end

  // channel alpha dividers
  logic          v1 [3];
  logic [NW-1:0] q1 [3];
  logic [SW1-1:0] s1 [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_div1
    logic [NA-1:0] nmag;
    logic [KW-1:0] dmag;
    logic          sgn;
    dkm_ctl_t      ctl;

    assign nmag      = a_num[ch][NA-1] ? NA'(-a_num[ch]) : NA'(a_num[ch]);
    assign dmag      = a_den[ch][KW-1] ? KW'(-a_den[ch]) : KW'(a_den[ch]);
    assign sgn       = a_num[ch][NA-1] ^ a_den[ch][KW-1];
    assign ctl.en    = en;
    assign ctl.valid = a_valid;

    dkm_div #(.NW(NW), .DW(KW), .SW(SW1)) u_div (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .num      ({nmag, {F{1'b0}}}),
      .den      (dmag),
      .side_in  ({a_zero[ch], sgn, a_n2[ch], a_ksum[ch]}),
      .out_valid(v1[ch]),
      .quo      (q1[ch]),
      .side_out (s1[ch])
    );
  end

  // common data riding alongside the first divider
  logic [CW1-1:0] com1_q [NW];
  always_ff @(posedge clk) begin
    if (en) begin
      com1_q[0] <= {a_eq, a_avg, a_main[0], a_main[1], a_main[2], a_last};
      for (int i = 1; i < NW; i++) begin
        com1_q[i] <= com1_q[i-1];
      end
    end
  end

  // stage c: signed, saturated channel alphas
  logic                 c_valid;
  logic signed [V-1:0]  c_alpha [3];
  logic signed [NA-1:0] c_n2    [3];
  logic signed [KW-1:0] c_ksum  [3];
  logic [CW1-1:0]       c_com;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= v1[0];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [NW:0] sq;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq = s1[i][SW1-2] ? -$signed({1'b0, q1[i]}) : $signed({1'b0, q1[i]});
        c_alpha[i] <= s1[i][SW1-1] ? '0 : sat_v(SATW'(sq));
        c_n2[i]    <= s1[i][KW +: NA];
        c_ksum[i]  <= s1[i][KW-1:0];
      end
      c_com <= com1_q[NW-1];
    end
  end

  // stage d: largest channel alpha
  logic                 d_valid;
  logic signed [V-1:0]  d_alpha;
  logic signed [NA-1:0] d_n2   [3];
  logic signed [KW-1:0] d_ksum [3];
  logic [CW1-1:0]       d_com;
  logic signed [V-1:0]  m01;

  assign m01 = (c_alpha[1] > c_alpha[0]) ? c_alpha[1] : c_alpha[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_alpha <= (c_alpha[2] > m01) ? c_alpha[2] : m01;
      d_n2    <= c_n2;
      d_ksum  <= c_ksum;
      d_com   <= c_com;
    end
  end

  // alpha output product and un-mix dividers
  logic                d_eq;
  logic signed [V-1:0] d_avg;
  logic [3*V:0]        d_pix;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;

  assign d_eq    = d_com[CW1-1];
  assign d_avg   = d_com[CW1-2 -: V];
  assign d_pix   = d_com[3*V:0];
  assign prod    = PW'(d_avg) * PW'(d_alpha);
  assign prod_sh = prod >>> F;

  logic          v2 [3];
  logic [NW-1:0] q2 [3];
  logic [SW2-1:0] s2 [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_div2
    logic [NA-1:0] nmag;
    logic [V-1:0]  dmag;
    logic          sgn;
    dkm_ctl_t      ctl;

    assign nmag      = d_n2[ch][NA-1] ? NA'(-d_n2[ch]) : NA'(d_n2[ch]);
    assign dmag      = d_alpha[V-1] ? V'(-d_alpha) : V'(d_alpha);
    assign sgn       = d_n2[ch][NA-1] ^ d_alpha[V-1];
    assign ctl.en    = en;
    assign ctl.valid = d_valid;

    dkm_div #(.NW(NW), .DW(V), .SW(SW2)) u_div (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .num      ({nmag, {F{1'b0}}}),
      .den      (dmag),
      .side_in  ({sgn, d_ksum[ch]}),
      .out_valid(v2[ch]),
      .quo      (q2[ch]),
      .side_out (s2[ch])
    );
  end

  logic [CW2-1:0] com2_q [NW];
  always_ff @(posedge clk) begin
    if (en) begin
      com2_q[0] <= {d_eq, (d_alpha == '0), d_avg, d_pix, prod_sh};
      for (int i = 1; i < NW; i++) begin
        com2_q[i] <= com2_q[i-1];
      end
    end
  end

  // stage e: un-mix, saturate and select the result
  logic                 e_eq;
  logic                 e_zero;
  logic signed [V-1:0]  e_avg;
  logic signed [V-1:0]  e_main [3];
  logic                 e_last;
  logic signed [PW-1:0] e_prod;
  logic signed [V-1:0]  e_col  [3];
  logic signed [V-1:0]  res    [3];
  logic signed [V-1:0]  res_a;

  assign e_eq      = com2_q[NW-1][CW2-1];
  assign e_zero    = com2_q[NW-1][CW2-2];
  assign e_avg     = com2_q[NW-1][CW2-3 -: V];
  assign e_main[0] = com2_q[NW-1][PW+1+2*V +: V];
  assign e_main[1] = com2_q[NW-1][PW+1+V +: V];
  assign e_main[2] = com2_q[NW-1][PW+1 +: V];
  assign e_last    = com2_q[NW-1][PW];
  assign e_prod    = com2_q[NW-1][PW-1:0];

  always_comb begin
    logic signed [NW+1:0] sq;
    logic signed [NW+1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sq  = s2[i][SW2-1] ? -$signed({2'b00, q2[i]}) : $signed({2'b00, q2[i]});
      sum = sq + (NW+2)'($signed(s2[i][KW-1:0]));
      e_col[i] = sat_v(SATW'(sum >>> 1));
    end
    if (e_eq) begin
      res   = e_main;
      res_a = e_avg;
    end else if (e_zero) begin
      res   = '{default: '0};
      res_a = '0;
    end else begin
      res   = e_col;
      res_a = sat_v(SATW'(e_prod));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x     <= res[0];
      out_y     <= res[1];
      out_z     <= res[2];
      out_alpha <= res_a;
      last_out  <= e_last;
    end
  end

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // the three channel dividers stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (v1[0] == v1[1]) && (v1[0] == v1[2]) && (v2[0] == v2[1]) && (v2[0] == v2[2]))
    else $error("channel dividers out of step");

  // chosen alpha is the largest of the channel alphas
  a_max: assert property (@(posedge clk) disable iff (rst)
    ($past(en) && d_valid) |-> ((d_alpha >= $past(c_alpha[0])) &&
      (d_alpha >= $past(c_alpha[1])) && (d_alpha >= $past(c_alpha[2]))))
    else $error("alpha is not the channel maximum");

endmodule
`default_nettype wire
